>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks (box_filter_running_sum.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/bfrs_pkg.sv
`timescale 1ns / 1ps

package bfrs_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int SAMPLE_W    = 16;
  localparam int WSIZE_BITS  = 7;
  localparam int RECIP_BITS  = 17;
  localparam int MEAN_BITS   = 24;
  localparam int FRAC_SHIFT  = 8;
  localparam int DATA_BITS   = 32;
  localparam int PADDR_BITS  = 3;

  localparam int STORE_BITS  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int PTR_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS    = STORE_BITS + PTR_BITS;
  localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
  localparam int WIDE_BITS   = (PROD_BITS > FRAC_SHIFT + MEAN_BITS) ?
                               PROD_BITS : FRAC_SHIFT + MEAN_BITS;

  localparam logic [WSIZE_BITS-1:0] WINDOW_SIZE_RESET = 7'd7;
  localparam logic [RECIP_BITS-1:0] RECIP_RESET       = 17'd9362;

  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_RECIPROCAL  = 1'b1;

  typedef struct packed {
    logic                  step;
    logic                  clear;
    logic                  line_start;
    logic [STORE_BITS-1:0] sample;
  } win_req_t;

  typedef struct packed {
    logic                full;
    logic [SUM_BITS-1:0] sum;
  } win_res_t;

  // Window length in use: zero counts as one, large values saturate.
  function automatic logic [CNT_BITS-1:0] eff_window(input logic [WSIZE_BITS-1:0] ws);
    logic [CNT_BITS-1:0] w;
    if (ws == '0) begin
      w = CNT_BITS'(1);
    end else if (32'(ws) > 32'(MAX_WINDOW)) begin
      w = CNT_BITS'(MAX_WINDOW);
    end else begin
      w = CNT_BITS'(ws);
    end
    return w;
  endfunction

  // Drops the fraction bits beyond Q16.8 and saturates to the mean width.
  function automatic logic [MEAN_BITS-1:0] sat_mean(input logic [PROD_BITS-1:0] prod);
    logic [WIDE_BITS-1:0] x;
    logic [MEAN_BITS-1:0] m;
    x = WIDE_BITS'(prod) >> FRAC_SHIFT;
    if (x > WIDE_BITS'({MEAN_BITS{1'b1}})) begin
      m = {MEAN_BITS{1'b1}};
    end else begin
      m = MEAN_BITS'(x);
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/bfrs_window.sv
`timescale 1ns / 1ps

module bfrs_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bfrs_pkg::CNT_BITS-1:0]  win_len,
  input  bfrs_pkg::win_req_t             req,
  output bfrs_pkg::win_res_t             res
);

  logic [bfrs_pkg::STORE_BITS-1:0] store [bfrs_pkg::MAX_WINDOW];

  logic [bfrs_pkg::SUM_BITS-1:0]   running_sum;
  logic [bfrs_pkg::SUM_BITS-1:0]   running_sum_next;
  logic [bfrs_pkg::CNT_BITS-1:0]   fill_count;
  logic [bfrs_pkg::CNT_BITS-1:0]   fill_count_next;
  logic [bfrs_pkg::PTR_BITS-1:0]   write_pointer;
  logic [bfrs_pkg::PTR_BITS-1:0]   write_pointer_next;
  logic [bfrs_pkg::STORE_BITS-1:0] oldest;

  logic [bfrs_pkg::SUM_BITS-1:0]   sum_base;
  logic [bfrs_pkg::SUM_BITS-1:0]   sum_step;
  logic [bfrs_pkg::CNT_BITS-1:0]   cnt_base;
  logic [bfrs_pkg::CNT_BITS-1:0]   cnt_step;
  logic [bfrs_pkg::PTR_BITS-1:0]   ptr;
  logic [bfrs_pkg::PTR_BITS-1:0]   ptr_step;
  logic                            was_full;

  always_comb begin
    if (req.line_start) begin
      sum_base = '0;
      cnt_base = '0;
      ptr      = '0;
    end else begin
      sum_base = running_sum;
      cnt_base = fill_count;
      ptr      = (bfrs_pkg::CNT_BITS'(write_pointer) >= win_len) ? '0 : write_pointer;
    end

    was_full = (cnt_base >= win_len);
    sum_step = sum_base - (was_full ? bfrs_pkg::SUM_BITS'(oldest) : '0)
               + bfrs_pkg::SUM_BITS'(req.sample);

    if (bfrs_pkg::CNT_BITS'(ptr) + bfrs_pkg::CNT_BITS'(1) >= win_len) begin
      ptr_step = '0;
    end else begin
      ptr_step = ptr + bfrs_pkg::PTR_BITS'(1);
    end

    cnt_step = (cnt_base < win_len) ? cnt_base + bfrs_pkg::CNT_BITS'(1) : cnt_base;

    res.full = (cnt_step >= win_len);
    res.sum  = sum_step;

    if (req.clear) begin
      running_sum_next   = '0;
      fill_count_next    = '0;
      write_pointer_next = '0;
    end else if (req.step) begin
      running_sum_next   = sum_step;
      fill_count_next    = cnt_step;
      write_pointer_next = ptr_step;
    end else begin
      running_sum_next   = running_sum;
      fill_count_next    = fill_count;
      write_pointer_next = write_pointer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      fill_count    <= '0;
      write_pointer <= '0;
    end else begin
      running_sum   <= running_sum_next;
      fill_count    <= fill_count_next;
      write_pointer <= write_pointer_next;
    end
  end

  // The oldest sample is prefetched from the slot that write_pointer_next names; a write to the same slot is forwarded.
  always_ff @(posedge clk) begin
    if (req.step) begin
      store[ptr] <= req.sample;
    end
    if (req.step && (ptr == write_pointer_next)) begin
      oldest <= req.sample;
    end else begin
      oldest <= store[write_pointer_next];
    end
  end

endmodule

>>> hw/rtl/box_filter_running_sum.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sliding box filter over a line of samples. One sample request is taken in every clock
// unless sample_stall holds it off; once the window holds window_size samples (zero counts
// as one, capped at 64) each request yields one mean, sum times reciprocal_q16 shifted
// right by eight (Q16.8, saturated to 24 bits), which passes through the sum, product and
// output registers. The rate is set by the running sum loop, which adds the new sample and
// subtracts the oldest one, prefetched from the window memory, in one combinational step.
// A request flagged line_start empties the window first, as does a write of window_size.

module box_filter_running_sum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic [bfrs_pkg::SAMPLE_W-1:0]     sample,
  input  logic                              line_start,
  input  logic                              line_end,
  output logic                              mean_valid,
  input  logic                              mean_stall,
  output logic [bfrs_pkg::MEAN_BITS-1:0]    mean_value,
  output logic                              last_of_line,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bfrs_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [bfrs_pkg::DATA_BITS-1:0]    pwdata,
  output logic [bfrs_pkg::DATA_BITS-1:0]    prdata,
  output logic                              pready
);

  logic [bfrs_pkg::WSIZE_BITS-1:0] window_size;
  logic [bfrs_pkg::RECIP_BITS-1:0] reciprocal_q16;
  logic [bfrs_pkg::CNT_BITS-1:0]   win_len;
  logic                            cfg_write;
  logic                            size_write;

  logic                            in_valid;
  logic [bfrs_pkg::STORE_BITS-1:0] in_sample;
  logic                            in_start;
  logic                            in_end;

  logic                            s_valid;
  logic [bfrs_pkg::SUM_BITS-1:0]   s_sum;
  logic                            s_last;

  logic                            m_valid;
  logic [bfrs_pkg::PROD_BITS-1:0]  m_prod;
  logic                            m_last;

  logic                            o_move;
  logic                            m_move;
  logic                            s_move;
  logic                            step;

  bfrs_pkg::win_req_t              win_req;
  bfrs_pkg::win_res_t              win_res;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign size_write = cfg_write && (paddr[2] == bfrs_pkg::REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= bfrs_pkg::WINDOW_SIZE_RESET;
      reciprocal_q16 <= bfrs_pkg::RECIP_RESET;
      win_len        <= bfrs_pkg::eff_window(bfrs_pkg::WINDOW_SIZE_RESET);
    end else if (cfg_write) begin
      case (paddr[2])
        bfrs_pkg::REG_WINDOW_SIZE: begin
          window_size <= pwdata[bfrs_pkg::WSIZE_BITS-1:0];
          win_len     <= bfrs_pkg::eff_window(pwdata[bfrs_pkg::WSIZE_BITS-1:0]);
        end
        bfrs_pkg::REG_RECIPROCAL: begin
          reciprocal_q16 <= pwdata[bfrs_pkg::RECIP_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bfrs_pkg::REG_WINDOW_SIZE: prdata = bfrs_pkg::DATA_BITS'(window_size);
      bfrs_pkg::REG_RECIPROCAL:  prdata = bfrs_pkg::DATA_BITS'(reciprocal_q16);
      default:                   prdata = '0;
    endcase
  end

  assign o_move       = !mean_valid || !mean_stall;
  assign m_move       = !m_valid || o_move;
  assign s_move       = !s_valid || m_move;
  assign step         = in_valid && s_move;
  assign sample_stall = in_valid && !s_move;

  assign win_req.step       = step;
  assign win_req.clear      = size_write;
  assign win_req.line_start = in_start;
  assign win_req.sample     = in_sample;

  bfrs_window u_window (
    .clk     (clk),
    .rst     (rst),
    .win_len (win_len),
    .req     (win_req),
    .res     (win_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      s_valid    <= 1'b0;
      m_valid    <= 1'b0;
      mean_valid <= 1'b0;
    end else begin
      if (!sample_stall) begin
        in_valid <= sample_valid;
      end
      if (s_move) begin
        s_valid <= step && win_res.full;
      end
      if (m_move) begin
        m_valid <= s_valid;
      end
      if (o_move) begin
        mean_valid <= m_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      in_sample <= sample[bfrs_pkg::STORE_BITS-1:0];
      in_start  <= line_start;
      in_end    <= line_end;
    end
    if (s_move) begin
      s_sum  <= win_res.sum;
      s_last <= in_end;
    end
    if (m_move) begin
      m_prod <= bfrs_pkg::PROD_BITS'(s_sum) * bfrs_pkg::PROD_BITS'(reciprocal_q16);
      m_last <= s_last;
    end
    if (o_move) begin
      mean_value   <= bfrs_pkg::sat_mean(m_prod);
      last_of_line <= m_last;
    end
  end

  `ASSERT_NEXT(a_no_mean_before_full, clk, rst, step && !win_res.full, !s_valid)
  `ASSERT_IMP(a_stall_only_when_held, clk, rst, sample_stall, in_valid && s_valid && m_valid)
  `ASSERT_NEXT(a_product_held, clk, rst, m_valid && !o_move, m_valid)

endmodule
